[design/tridiagonal_lu_pivot_stream_core_defines.svh]
// Assertion macros used by the checker file.
`ifndef TRIDIAGONAL_LU_PIVOT_STREAM_CORE_DEFINES_SVH
`define TRIDIAGONAL_LU_PIVOT_STREAM_CORE_DEFINES_SVH

// Clocked assertion, muted while reset is high.
`define TDLU_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define TDLU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/tdlu_pkg.sv]
`timescale 1ns / 1ps
package tdlu_pkg;
   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int CNT_W      = $clog2(DATA_WIDTH + 1);

   typedef logic [DATA_WIDTH-1:0] data_type;

   // Command into the divider
   typedef struct packed {
      logic     start;
      data_type num_mag;
      data_type den_mag;
   } div_cmd_type;

   // Status back from the divider
   typedef struct packed {
      logic     done;
      logic     over;
      data_type q_mag;
   } div_stat_type;

   // Magnitude of a two's complement value, as unsigned
   function automatic data_type mag_of(input data_type v);
      mag_of = v[DATA_WIDTH-1] ? (~v + data_type'(1)) : v;
   endfunction
endpackage

[design/tdlu_div.sv]
`timescale 1ns / 1ps
module tdlu_div import tdlu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  div_cmd_type  cmd,
   output div_stat_type stat
);
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   data_type         rem_ff, rem_in;
   data_type         num_ff, num_in;
   data_type         quo_ff, quo_in;
   data_type         den_ff, den_in;
   logic             over_ff, over_in;
   logic             done_ff, done_in;
   logic [DATA_WIDTH:0] trial;
   logic             ge;

   // One restoring step: shift in a numerator bit, subtract if it fits
   always_comb begin
      trial = {rem_ff, num_ff[DATA_WIDTH-1]};
      ge    = trial >= {1'b0, den_ff};
   end

   always_comb begin
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      over_in = over_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         // Load: high part of (num << FRAC_BITS) seeds the remainder
         rem_in  = data_type'(cmd.num_mag >> (DATA_WIDTH - FRAC_BITS));
         num_in  = cmd.num_mag << FRAC_BITS;
         den_in  = cmd.den_mag;
         quo_in  = '0;
         over_in = data_type'(cmd.num_mag >> (DATA_WIDTH - FRAC_BITS)) >= cmd.den_mag;
         cnt_in  = CNT_W'(DATA_WIDTH);
      end else if (cnt_ff != '0) begin
         rem_in  = ge ? data_type'(trial - {1'b0, den_ff}) : trial[DATA_WIDTH-1:0];
         num_in  = num_ff << 1;
         quo_in  = {quo_ff[DATA_WIDTH-2:0], ge};
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = cnt_ff == CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
      over_ff <= over_in;
   end

   assign stat.done  = done_ff;
   assign stat.over  = over_ff;
   assign stat.q_mag = quo_ff;
endmodule

[design/tridiagonal_lu_pivot_stream_core.sv]
`timescale 1ns / 1ps
// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  tdata: sub, main, super; tuser: first_row
// rsp      out  rsp_tvalid/rsp_tready  tdata: pivot; tuser: zero_pivot, saturated
//
// A later row with a nonzero previous pivot passes these steps after accept:
// 32 restoring steps of the radix-2 divider, then one quotient clip, one multiply
// and one subtract/clip step.
// A first row or a zero previous pivot skips straight to the subtract/clip step.
// One row is in flight at a time; req_tready is high only while idle. Reset is
// synchronous; a stalled result holds the row in its last step until the result register can take it.
module tridiagonal_lu_pivot_stream_core import tdlu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // [31:0] sub_diag, [63:32] main_diag, [95:64] super_diag
   input  logic [0:0]  req_tuser,   // [0] first_row
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] pivot
   output logic [1:0]  rsp_tuser    // [0] zero_pivot, [1] saturated
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_MUL  = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0] state_ff, state_in;
   data_type   a_ff, a_in, b_ff, b_in, c_ff, c_in;
   data_type   last_pivot_ff, last_pivot_in, last_super_ff, last_super_in;
   logic       zero_ff, zero_in, sat_ff, sat_in;
   data_type   q_mag_ff, q_mag_in;
   logic       q_neg_ff, q_neg_in;
   logic [2*DATA_WIDTH-1:0] mul_ff, mul_in;
   logic       p_neg_ff, p_neg_in;
   logic       rsp_valid_ff, rsp_valid_in;
   data_type   rsp_pivot_ff, rsp_pivot_in;
   logic       rsp_zero_ff, rsp_zero_in, rsp_sat_ff, rsp_sat_in;

   div_cmd_type  div_cmd;
   div_stat_type div_stat;

   data_type   qlim;
   logic [2*DATA_WIDTH-1:0] r_mag, plim;
   logic       p_clip;
   data_type   p_mag;
   logic signed [DATA_WIDTH:0]   prod;
   logic signed [DATA_WIDTH+1:0] diff;
   logic       d_clip;
   data_type   piv;
   logic       out_free;

   tdlu_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .stat  (div_stat)
   );

   assign req_tready = state_ff == ST_IDLE;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Final step: clip the product, subtract from the diagonal, clip again
   always_comb begin
      qlim   = {q_neg_ff, {(DATA_WIDTH-1){~q_neg_ff}}};
      r_mag  = mul_ff >> FRAC_BITS;
      plim   = {{DATA_WIDTH{1'b0}}, p_neg_ff, {(DATA_WIDTH-1){~p_neg_ff}}};
      p_clip = r_mag > plim;
      p_mag  = p_clip ? plim[DATA_WIDTH-1:0] : r_mag[DATA_WIDTH-1:0];
      prod   = p_neg_ff ? -$signed({1'b0, p_mag}) : $signed({1'b0, p_mag});
      diff   = $signed({{2{b_ff[DATA_WIDTH-1]}}, b_ff}) - $signed({prod[DATA_WIDTH], prod});
      d_clip = !((diff[DATA_WIDTH+1:DATA_WIDTH-1] == 3'b000) ||
                 (diff[DATA_WIDTH+1:DATA_WIDTH-1] == 3'b111));
      piv    = d_clip ? {diff[DATA_WIDTH+1], {(DATA_WIDTH-1){~diff[DATA_WIDTH+1]}}}
                      : diff[DATA_WIDTH-1:0];
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      c_in          = c_ff;
      last_pivot_in = last_pivot_ff;
      last_super_in = last_super_ff;
      zero_in       = zero_ff;
      sat_in        = sat_ff;
      q_mag_in      = q_mag_ff;
      q_neg_in      = q_neg_ff;
      mul_in        = mul_ff;
      p_neg_in      = p_neg_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_pivot_in  = rsp_pivot_ff;
      rsp_zero_in   = rsp_zero_ff;
      rsp_sat_in    = rsp_sat_ff;
      div_cmd.start   = 1'b0;
      div_cmd.num_mag = mag_of(last_super_ff);
      div_cmd.den_mag = mag_of(last_pivot_ff);
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               a_in     = req_tdata[31:0];
               b_in     = req_tdata[63:32];
               c_in     = req_tdata[95:64];
               sat_in   = 1'b0;
               zero_in  = 1'b0;
               q_neg_in = last_super_ff[DATA_WIDTH-1] ^ last_pivot_ff[DATA_WIDTH-1];
               if (req_tuser[0] || last_pivot_ff == '0) begin
                  // Skip the divide: product is zero
                  zero_in  = !req_tuser[0];
                  mul_in   = '0;
                  p_neg_in = 1'b0;
                  state_in = ST_FIN;
               end else begin
                  div_cmd.start = 1'b1;
                  state_in      = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               if (div_stat.over || div_stat.q_mag > qlim) begin
                  q_mag_in = qlim;
                  sat_in   = 1'b1;
               end else begin
                  q_mag_in = div_stat.q_mag;
               end
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            mul_in   = {{DATA_WIDTH{1'b0}}, mag_of(a_ff)} * {{DATA_WIDTH{1'b0}}, q_mag_ff};
            p_neg_in = a_ff[DATA_WIDTH-1] ^ (q_neg_ff && q_mag_ff != '0);
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // Hold until the result register can take the row
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_pivot_in  = piv;
               rsp_zero_in   = zero_ff;
               rsp_sat_in    = sat_ff || p_clip || d_clip;
               last_pivot_in = piv;
               last_super_in = c_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         last_pivot_ff <= '0;
         last_super_ff <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         last_pivot_ff <= last_pivot_in;
         last_super_ff <= last_super_in;
      end
      a_ff         <= a_in;
      b_ff         <= b_in;
      c_ff         <= c_in;
      zero_ff      <= zero_in;
      sat_ff       <= sat_in;
      q_mag_ff     <= q_mag_in;
      q_neg_ff     <= q_neg_in;
      mul_ff       <= mul_in;
      p_neg_ff     <= p_neg_in;
      rsp_pivot_ff <= rsp_pivot_in;
      rsp_zero_ff  <= rsp_zero_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pivot_ff;
   assign rsp_tuser  = {rsp_sat_ff, rsp_zero_ff};
endmodule

[design/tdlu_chk.sv]
`timescale 1ns / 1ps
`include "tridiagonal_lu_pivot_stream_core_defines.svh"
module tdlu_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);
   // Result held while stalled
   `TDLU_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "rsp_tvalid dropped while stalled")
   `TDLU_ASSERT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser), "rsp payload changed while stalled")
   // Busy right after taking a request
   `TDLU_ASSERT(a_busy, clock, reset, req_tvalid && req_tready |=> !req_tready, "request taken while a row is in flight")
   // Nothing to deliver right after reset
   `TDLU_ASSERT_ALWAYS(a_rst_empty, clock, $past(reset) |-> !rsp_tvalid, "result valid right after reset")
   // A zero previous pivot leaves the diagonal unchanged, so nothing clips
   `TDLU_ASSERT(a_zero_nosat, clock, reset, rsp_tvalid && rsp_tuser[0] |-> !rsp_tuser[1], "zero pivot result flagged as saturated")
endmodule

bind tridiagonal_lu_pivot_stream_core tdlu_chk u_tdlu_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
